// ===== rtl/core/population_model_euler_step_top_macros.svh =====
// Assertion shorthands used by the top-level RTL file.
// Each expects clk and arst_n in scope.
`ifndef POPULATION_MODEL_EULER_STEP_TOP_MACROS_SVH
`define POPULATION_MODEL_EULER_STEP_TOP_MACROS_SVH

// Same-cycle implication.
`define PMES_ASSERT_NOW(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("pmes: same-cycle check failed");

// Next-cycle implication.
`define PMES_ASSERT_NEXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("pmes: next-cycle check failed");

`endif

// ===== rtl/core/pmes_pkg.sv =====
`default_nettype none
package pmes_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 48;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_HEALTHY_DEATH = 4'd0;
	localparam cfg_idx_t REG_FAMINE_DEATH  = 4'd1;
	localparam cfg_idx_t REG_COMMONER_BIRTH = 4'd2;
	localparam cfg_idx_t REG_ELITE_BIRTH   = 4'd3;
	localparam cfg_idx_t REG_REGEN         = 4'd4;
	localparam cfg_idx_t REG_CAPACITY      = 4'd5;
	localparam cfg_idx_t REG_DEPLETION     = 4'd6;
	localparam cfg_idx_t REG_INEQUALITY    = 4'd7;

	// Fixed-point constants s and r in Q0.48
	localparam logic [37:0] S_Q48 = 38'd140737488355;
	localparam logic [40:0] R_Q48 = 41'd1407374883553;

	// Ratio divider: numerator w<<72, denominator r*base, quotient Q0.32
	localparam int NUM_W = 136;
	localparam int DEN_W = 138;
	localparam int Q_W   = 32;

	localparam logic [Q_W:0] ONE_Q32 = {1'b1, {Q_W{1'b0}}};
	localparam logic [56:0]  ONE_Q56 = {1'b1, 56'd0};

endpackage
`default_nettype wire

// ===== rtl/core/population_model_euler_step_top.sv =====
`default_nettype none
// One explicit Euler step of the commoner/elite/nature/wealth model per beat.
// A new item can enter every cycle while in_stall is low. The pipeline depth
// is set mostly by the restoring divider that forms the consumption ratio,
// plus the split multipliers around it. The whole pipeline advances as one:
// while a result waits under out_stall, every stage holds and in_stall is
// raised. Registers are written through the cfg port (cfg_ready is always
// high) by the user only while no item is in flight; the block does not
// enforce this. Indexes beyond the last register are ignored.
module population_model_euler_step_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pmes_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pmes_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [63:0]                     commoners_in,
	input  wire logic [63:0]                     elites_in,
	input  wire logic [63:0]                     nature_in,
	input  wire logic [63:0]                     wealth_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [63:0]                     commoners_out,
	output logic      [63:0]                     elites_out,
	output logic      [63:0]                     nature_out,
	output logic      [63:0]                     wealth_out,
	output logic                                 saturated
);

	localparam int PD = 48;

	// Configuration registers
	logic [31:0] am_q, af_q, bc_q, be_q, g_q, k_q;
	logic [39:0] l_q;
	logic [47:0] d_q;

	logic [PD-1:0] vld_q;
	logic          adv;

	// Datapath nets
	logic [95:0]  kxe, bxc, bxe, gn;
	logic [111:0] dx;
	logic [63:0]  xc_d2, n_d2, w_d5;
	logic [96:0]  base_s3;
	logic [175:0] dxn, dxn_d45;
	logic [135:0] gnl, gnl_d45;
	logic [159:0] gnn, gnn_d45;
	logic [137:0] den;
	logic [134:0] sb, sb_d38;
	logic [32:0]  ratio;
	logic [64:0]  ra, rf, qe;
	logic [167:0] wm, wm_d45;
	logic         full_d40, ef, ef_d42;
	logic [64:0]  crsum;
	logic [87:0]  ac88_s41, ac88_d43, ae88_s43, eam;
	logic [88:0]  eaf, esum;
	logic [151:0] mc, me;
	logic [63:0]  xc_d43, xe_d43, xc_d45, xe_d45, n_d45, w_d45;
	logic [95:0]  bxc_d45, bxe_d45;

	logic [152:0] cp_plus_s46, ep_plus_s46, np_plus_s46;
	logic [151:0] cp_minus_s46, ep_minus_s46;
	logic [176:0] np_minus_s46;
	logic [208:0] wp_plus_s46;
	logic [167:0] wp_minus_s46;

	logic [152:0] cd_s47, ed_s47;
	logic [176:0] nd_s47;
	logic [208:0] wd_s47;
	logic         cpos_s47, epos_s47, npos_s47, wpos_s47;

	logic [153:0] cr, er;
	logic [177:0] nr;
	logic [209:0] wr;
	logic [65:0]  cv, ev;
	logic [105:0] nv;
	logic [81:0]  wv;
	logic         csat, esat, nsat, wsat;

	logic [63:0] commoners_s48, elites_s48, nature_s48, wealth_s48;
	logic        sat_s48;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			am_q <= 32'd42949673;
			af_q <= 32'd300647710;
			bc_q <= 32'd128849019;
			be_q <= 32'd128849019;
			g_q  <= 32'd42949673;
			l_q  <= 40'd1677721600;
			d_q  <= '0;
			k_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pmes_pkg::REG_HEALTHY_DEATH:  am_q <= cfg_data[31:0];
				pmes_pkg::REG_FAMINE_DEATH:   af_q <= cfg_data[31:0];
				pmes_pkg::REG_COMMONER_BIRTH: bc_q <= cfg_data[31:0];
				pmes_pkg::REG_ELITE_BIRTH:    be_q <= cfg_data[31:0];
				pmes_pkg::REG_REGEN:          g_q  <= cfg_data[31:0];
				pmes_pkg::REG_CAPACITY:       l_q  <= cfg_data[39:0];
				pmes_pkg::REG_DEPLETION:      d_q  <= cfg_data[47:0];
				pmes_pkg::REG_INEQUALITY:     k_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Advance all stages unless the finished result is held
	assign adv      = !(vld_q[PD-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PD-2:0], in_valid};
		end
	end

	// Input products (ready at stage 2)
	pmes_mul #(.WA(32), .WB(64)) u_kxe (.clk, .en(adv), .a(k_q),  .b(elites_in),    .p(kxe));
	pmes_mul #(.WA(32), .WB(64)) u_bxc (.clk, .en(adv), .a(bc_q), .b(commoners_in), .p(bxc));
	pmes_mul #(.WA(32), .WB(64)) u_bxe (.clk, .en(adv), .a(be_q), .b(elites_in),    .p(bxe));
	pmes_mul #(.WA(48), .WB(64)) u_dx  (.clk, .en(adv), .a(d_q),  .b(commoners_in), .p(dx));
	pmes_mul #(.WA(32), .WB(64)) u_gn  (.clk, .en(adv), .a(g_q),  .b(nature_in),    .p(gn));

	pmes_dly #(.W(64), .N(2)) u_xc_d2 (.clk, .en(adv), .d(commoners_in), .q(xc_d2));
	pmes_dly #(.W(64), .N(2)) u_n_d2  (.clk, .en(adv), .d(nature_in),    .q(n_d2));
	pmes_dly #(.W(64), .N(5)) u_w_d5  (.clk, .en(adv), .d(wealth_in),    .q(w_d5));

	// Threshold base xc + k*xe in Q.48
	always_ff @(posedge clk) begin
		if (adv) begin
			base_s3 <= 97'({xc_d2, 24'd0}) + 97'(kxe);
		end
	end

	// Nature terms (ready at stage 4)
	pmes_mul #(.WA(112), .WB(64)) u_dxn (.clk, .en(adv), .a(dx), .b(n_d2), .p(dxn));
	pmes_mul #(.WA(96),  .WB(40)) u_gnl (.clk, .en(adv), .a(gn), .b(l_q),  .p(gnl));
	pmes_mul #(.WA(96),  .WB(64)) u_gnn (.clk, .en(adv), .a(gn), .b(n_d2), .p(gnn));

	// Denominator r*base and s*base (ready at stage 5)
	pmes_mul #(.WA(41), .WB(97)) u_den (.clk, .en(adv), .a(pmes_pkg::R_Q48), .b(base_s3),
		.p(den));
	pmes_mul #(.WA(38), .WB(97)) u_sb (.clk, .en(adv), .a(pmes_pkg::S_Q48), .b(base_s3),
		.p(sb));

	// Consumption ratio (ready at stage 38)
	pmes_div u_div (.clk, .en(adv), .num({w_d5, 72'd0}), .den(den), .ratio(ratio));

	pmes_dly #(.W(135), .N(33)) u_sb_d38 (.clk, .en(adv), .d(sb), .q(sb_d38));

	// Ratio products (ready at stage 40)
	pmes_mul #(.WA(33), .WB(32)) u_ra (.clk, .en(adv), .a(ratio), .b(am_q), .p(ra));
	pmes_mul #(.WA(33), .WB(32)) u_rf (.clk, .en(adv), .a(pmes_pkg::ONE_Q32 - ratio),
		.b(af_q), .p(rf));
	pmes_mul #(.WA(33), .WB(32)) u_qe (.clk, .en(adv), .a(ratio), .b(k_q), .p(qe));
	pmes_mul #(.WA(33), .WB(135)) u_wm (.clk, .en(adv), .a(ratio), .b(sb_d38), .p(wm));

	pmes_dly #(.W(1), .N(2)) u_full_d40 (.clk, .en(adv), .d(ratio[32]), .q(full_d40));

	// Commoner death rate in Q0.88
	assign crsum = ra + rf;

	always_ff @(posedge clk) begin
		if (adv) begin
			ac88_s41 <= full_d40 ? {am_q, 56'd0} : {crsum[63:0], 24'd0};
		end
	end

	pmes_dly #(.W(88), .N(2)) u_ac88_d43 (.clk, .en(adv), .d(ac88_s41), .q(ac88_d43));

	// Elite death rate: quotient ratio*k in Q0.56
	assign ef = qe[64:56] != '0;

	pmes_mul #(.WA(56), .WB(32)) u_eam (.clk, .en(adv), .a(qe[55:0]), .b(am_q), .p(eam));
	pmes_mul #(.WA(57), .WB(32)) u_eaf (.clk, .en(adv),
		.a(pmes_pkg::ONE_Q56 - {1'b0, qe[55:0]}), .b(af_q), .p(eaf));
	pmes_dly #(.W(1), .N(2)) u_ef_d42 (.clk, .en(adv), .d(ef), .q(ef_d42));

	assign esum = 89'(eam) + eaf;

	always_ff @(posedge clk) begin
		if (adv) begin
			ae88_s43 <= ef_d42 ? {am_q, 56'd0} : esum[87:0];
		end
	end

	// Death losses (ready at stage 45)
	pmes_dly #(.W(64), .N(43)) u_xc_d43 (.clk, .en(adv), .d(commoners_in), .q(xc_d43));
	pmes_dly #(.W(64), .N(43)) u_xe_d43 (.clk, .en(adv), .d(elites_in),    .q(xe_d43));

	pmes_mul #(.WA(88), .WB(64)) u_mc (.clk, .en(adv), .a(ac88_d43), .b(xc_d43), .p(mc));
	pmes_mul #(.WA(88), .WB(64)) u_me (.clk, .en(adv), .a(ae88_s43), .b(xe_d43), .p(me));

	// Align remaining terms to stage 45
	pmes_dly #(.W(64),  .N(2))  u_xc_d45  (.clk, .en(adv), .d(xc_d43), .q(xc_d45));
	pmes_dly #(.W(64),  .N(2))  u_xe_d45  (.clk, .en(adv), .d(xe_d43), .q(xe_d45));
	pmes_dly #(.W(96),  .N(43)) u_bxc_d45 (.clk, .en(adv), .d(bxc),    .q(bxc_d45));
	pmes_dly #(.W(96),  .N(43)) u_bxe_d45 (.clk, .en(adv), .d(bxe),    .q(bxe_d45));
	pmes_dly #(.W(64),  .N(43)) u_n_d45   (.clk, .en(adv), .d(n_d2),   .q(n_d45));
	pmes_dly #(.W(64),  .N(40)) u_w_d45   (.clk, .en(adv), .d(w_d5),   .q(w_d45));
	pmes_dly #(.W(176), .N(41)) u_dxn_d45 (.clk, .en(adv), .d(dxn),    .q(dxn_d45));
	pmes_dly #(.W(136), .N(41)) u_gnl_d45 (.clk, .en(adv), .d(gnl),    .q(gnl_d45));
	pmes_dly #(.W(160), .N(41)) u_gnn_d45 (.clk, .en(adv), .d(gnn),    .q(gnn_d45));
	pmes_dly #(.W(168), .N(5))  u_wm_d45  (.clk, .en(adv), .d(wm),     .q(wm_d45));

	// Gather gains and losses
	always_ff @(posedge clk) begin
		if (adv) begin
			cp_plus_s46  <= 153'({xc_d45, 88'd0}) + 153'({bxc_d45, 56'd0});
			cp_minus_s46 <= mc;
			ep_plus_s46  <= 153'({xe_d45, 88'd0}) + 153'({bxe_d45, 56'd0});
			ep_minus_s46 <= me;
			np_plus_s46  <= 153'({n_d45, 72'd0}) + 153'({gnl_d45, 16'd0});
			np_minus_s46 <= 177'({gnn_d45, 16'd0}) + 177'(dxn_d45);
			wp_plus_s46  <= 209'({w_d45, 104'd0}) + 209'({dxn_d45, 32'd0});
			wp_minus_s46 <= wm_d45;
		end
	end

	// Net change and its sign
	always_ff @(posedge clk) begin
		if (adv) begin
			cd_s47   <= cp_plus_s46 - 153'(cp_minus_s46);
			cpos_s47 <= cp_plus_s46 > 153'(cp_minus_s46);
			ed_s47   <= ep_plus_s46 - 153'(ep_minus_s46);
			epos_s47 <= ep_plus_s46 > 153'(ep_minus_s46);
			nd_s47   <= 177'(np_plus_s46) - np_minus_s46;
			npos_s47 <= 177'(np_plus_s46) > np_minus_s46;
			wd_s47   <= wp_plus_s46 - 209'(wp_minus_s46);
			wpos_s47 <= wp_plus_s46 > 209'(wp_minus_s46);
		end
	end

	// Round half up to Q40.24 and detect overflow
	always_comb begin
		cr   = {1'b0, cd_s47} + (154'(1) << 87);
		er   = {1'b0, ed_s47} + (154'(1) << 87);
		nr   = {1'b0, nd_s47} + (178'(1) << 71);
		wr   = {1'b0, wd_s47} + (210'(1) << 127);
		cv   = cr[153:88];
		ev   = er[153:88];
		nv   = nr[177:72];
		wv   = wr[209:128];
		csat = cpos_s47 && (cv[65:64] != '0);
		esat = epos_s47 && (ev[65:64] != '0);
		nsat = npos_s47 && (nv[105:64] != '0);
		wsat = wpos_s47 && (wv[81:64] != '0);
	end

	// Clamp at zero, saturate at the top
	always_ff @(posedge clk) begin
		if (adv) begin
			commoners_s48 <= !cpos_s47 ? '0 : (csat ? '1 : cv[63:0]);
			elites_s48    <= !epos_s47 ? '0 : (esat ? '1 : ev[63:0]);
			nature_s48    <= !npos_s47 ? '0 : (nsat ? '1 : nv[63:0]);
			wealth_s48    <= !wpos_s47 ? '0 : (wsat ? '1 : wv[63:0]);
			sat_s48       <= csat || esat || nsat || wsat;
		end
	end

	assign out_valid     = vld_q[PD-1];
	assign commoners_out = commoners_s48;
	assign elites_out    = elites_s48;
	assign nature_out    = nature_s48;
	assign wealth_out    = wealth_s48;
	assign saturated     = sat_s48;

	`include "population_model_euler_step_top_macros.svh"

	`PMES_ASSERT_NEXT(a_hold_on_stall, !adv, vld_q == $past(vld_q))
	`PMES_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_q[0])
	`PMES_ASSERT_NOW(a_ratio_max_one, vld_q[37] && ratio[32], ratio[31:0] == '0)

endmodule
`default_nettype wire

// ===== rtl/core/pmes_mul.sv =====
`default_nettype none
// Two-stage multiplier: 32x32 partial products, then a registered sum.
module pmes_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WA-1:0]    a,
	input  wire logic [WB-1:0]    b,
	output logic      [WA+WB-1:0] p
);

	localparam int NA = (WA + 31) / 32;
	localparam int NB = (WB + 31) / 32;
	localparam int AW = (NA + NB) * 32;

	logic [NA*32-1:0] a_pad;
	logic [NB*32-1:0] b_pad;
	logic [63:0]      pp_s1 [NA][NB];
	logic [AW-1:0]    sum;
	logic [WA+WB-1:0] prod_s2;

	assign a_pad = (NA*32)'(a);
	assign b_pad = (NB*32)'(b);

	// Form all digit products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= a_pad[i*32 +: 32] * b_pad[j*32 +: 32];
				end
			end
		end
	end

	// Add shifted partials
	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (AW'(pp_s1[i][j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= sum[WA+WB-1:0];
		end
	end

	assign p = prod_s2;

endmodule
`default_nettype wire

// ===== rtl/core/pmes_dly.sv =====
`default_nettype none
// Fixed-length delay line that advances with the pipeline.
module pmes_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	// Shift one place per advance
	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign q = sr_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/pmes_div.sv =====
`default_nettype none
// Pipelined restoring divider for the consumption ratio, one quotient bit
// per stage. Gives one (2^32) when the denominator is zero or the
// numerator reaches it.
module pmes_div (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [pmes_pkg::NUM_W-1:0] num,
	input  wire logic [pmes_pkg::DEN_W-1:0] den,
	output logic      [pmes_pkg::Q_W:0]     ratio
);

	localparam int QW = pmes_pkg::Q_W;
	localparam int DW = pmes_pkg::DEN_W;
	localparam int RW = DW + 1;

	logic [RW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic          full_s [QW+1];

	// Latch operands and detect the saturated ratio
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= RW'(num);
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			full_s[0] <= (den == '0) || (DW'(num) >= den);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] rem2;
		logic          ge;

		// Shift in one bit and try the subtract
		always_comb begin
			rem2 = {rem_s[k][RW-2:0], 1'b0};
			ge   = rem2 >= RW'(den_s[k]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (rem2 - RW'(den_s[k])) : rem2;
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
				full_s[k+1] <= full_s[k];
			end
		end
	end

	assign ratio = full_s[QW] ? pmes_pkg::ONE_Q32 : {1'b0, quo_s[QW]};

endmodule
`default_nettype wire

// ===== dv/population_model_euler_step_checker.sv =====
`default_nettype none
module population_model_euler_step_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [pmes_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pmes_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [63:0]                     commoners_in,
	input  wire logic [63:0]                     elites_in,
	input  wire logic [63:0]                     nature_in,
	input  wire logic [63:0]                     wealth_in,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [63:0]                     commoners_out,
	input  wire logic [63:0]                     elites_out,
	input  wire logic [63:0]                     nature_out,
	input  wire logic [63:0]                     wealth_out,
	input  wire logic                            saturated,
	output int                                   mismatches,
	output int                                   pending,
	output int                                   compared
);

	typedef logic [255:0] wide_t;

	typedef struct packed {
		logic [63:0] commoners;
		logic [63:0] elites;
		logic [63:0] nature;
		logic [63:0] wealth;
		logic        sat;
	} step_t;

	// Register copies, Q formats as in the block
	logic [31:0] am_q, amax_q, bc_q, be_q, g_q, k_q;
	logic [39:0] cap_q;
	logic [47:0] dep_q;

	step_t next_states[$];

	// Exact difference rounded half up, clamped at zero, saturated at the top
	function automatic logic [64:0] round_clamp(wide_t plus, wide_t minus, int sh);
		wide_t v;
		wide_t half;
		half = wide_t'(1) << (sh - 1);
		if (minus >= plus)
			return 65'd0;
		v = ((plus - minus) + half) >> sh;
		if (v[255:64] != 0)
			return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
		return {1'b0, v[63:0]};
	endfunction

	// Death rate in Q0.88 from a Q0.56 quotient
	function automatic wide_t death_rate(wide_t q);
		wide_t one;
		wide_t am;
		wide_t amax;
		one = wide_t'(1) << 56;
		am = wide_t'(am_q);
		amax = wide_t'(amax_q);
		if (q >= one)
			return am << 56;
		return q * am + (one - q) * amax;
	endfunction

	function automatic logic [64:0] next_group(logic [63:0] x, logic [31:0] birth, wide_t a88);
		wide_t wx;
		wide_t plus;
		wide_t minus;
		wx = wide_t'(x);
		plus = (wx << 88) + ((wide_t'(birth) * wx) << 56);
		minus = a88 * wx;
		return round_clamp(plus, minus, 88);
	endfunction

	function automatic step_t euler_step(logic [63:0] xc, logic [63:0] xe,
			logic [63:0] n, logic [63:0] w);
		wide_t wxc, wxe, wn, ww, k, base, den, num, ratio, dxn, gn, plus, minus;
		logic [64:0] r0, r1, r2, r3;
		step_t s;
		wxc = wide_t'(xc);
		wxe = wide_t'(xe);
		wn = wide_t'(n);
		ww = wide_t'(w);
		k = wide_t'(k_q);
		base = (wxc << 24) + k * wxe;
		den = wide_t'(pmes_pkg::R_Q48) * base;
		num = ww << 72;
		if (den == 0 || num >= den)
			ratio = wide_t'(1) << 32;
		else
			ratio = (num << 32) / den;
		r0 = next_group(xc, bc_q, death_rate(ratio << 24));
		r1 = next_group(xe, be_q, death_rate(ratio * k));
		dxn = wide_t'(dep_q) * wxc * wn;
		gn = wide_t'(g_q) * wn;
		plus = (wn << 72) + ((gn * wide_t'(cap_q)) << 16);
		minus = ((gn * wn) << 16) + dxn;
		r2 = round_clamp(plus, minus, 72);
		plus = (ww << 104) + (dxn << 32);
		minus = ratio * wide_t'(pmes_pkg::S_Q48) * base;
		r3 = round_clamp(plus, minus, 128);
		s.commoners = r0[63:0];
		s.elites = r1[63:0];
		s.nature = r2[63:0];
		s.wealth = r3[63:0];
		s.sat = r0[64] | r1[64] | r2[64] | r3[64];
		return s;
	endfunction

	function automatic void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h got %h", what, exp_v, got_v);
	endfunction

	assign pending = next_states.size();

	// Track register writes, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		step_t e;
		if (!arst_n) begin
			am_q <= 32'd42949673;
			amax_q <= 32'd300647710;
			bc_q <= 32'd128849019;
			be_q <= 32'd128849019;
			g_q <= 32'd42949673;
			cap_q <= 40'd1677721600;
			dep_q <= 48'd0;
			k_q <= 32'd0;
			next_states.delete();
			mismatches <= 0;
			compared <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pmes_pkg::REG_HEALTHY_DEATH:  am_q <= cfg_data[31:0];
					pmes_pkg::REG_FAMINE_DEATH:   amax_q <= cfg_data[31:0];
					pmes_pkg::REG_COMMONER_BIRTH: bc_q <= cfg_data[31:0];
					pmes_pkg::REG_ELITE_BIRTH:    be_q <= cfg_data[31:0];
					pmes_pkg::REG_REGEN:          g_q <= cfg_data[31:0];
					pmes_pkg::REG_CAPACITY:       cap_q <= cfg_data[39:0];
					pmes_pkg::REG_DEPLETION:      dep_q <= cfg_data[47:0];
					pmes_pkg::REG_INEQUALITY:     k_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				compared <= compared + 1;
				if (next_states.size() == 0) begin
					report("unexpected beat", 64'd0, commoners_out);
				end else begin
					e = next_states.pop_front();
					if (e.commoners !== commoners_out) report("commoners", e.commoners, commoners_out);
					if (e.elites !== elites_out) report("elites", e.elites, elites_out);
					if (e.nature !== nature_out) report("nature", e.nature, nature_out);
					if (e.wealth !== wealth_out) report("wealth", e.wealth, wealth_out);
					if (e.sat !== saturated) report("saturated", 64'(e.sat), 64'(saturated));
				end
			end
			if (in_valid && !in_stall)
				next_states.push_back(euler_step(commoners_in, elites_in, nature_in, wealth_in));
		end
	end
endmodule
`default_nettype wire

// ===== dv/population_model_euler_step_top_test.sv =====
`default_nettype none
module population_model_euler_step_top_test;

	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pmes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pmes_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] commoners_in = '0, elites_in = '0, nature_in = '0, wealth_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] commoners_out, elites_out, nature_out, wealth_out;
	logic saturated;

	int mismatches, pending, compared;
	int cycles = 0;
	int items_sent = 0;
	bit quiet = 1'b0;
	int stall_left = 0;
	bit stalling = 1'b0;

	population_model_euler_step_top dut (.*);

	population_model_euler_step_checker checker_i (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .commoners_in, .elites_in, .nature_in, .wealth_in,
		.out_valid, .out_stall, .commoners_out, .elites_out, .nature_out, .wealth_out,
		.saturated, .mismatches, .pending, .compared
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL population_model_euler_step_top");
			$finish;
		end
	end

	// Output stall in random bursts, off once quiet
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stalling = ($urandom_range(0, 3) == 0);
			stall_left <= $urandom_range(1, 9);
			out_stall <= stalling;
		end
	end

	function automatic logic [63:0] pick_field();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2, 3: return {$urandom, $urandom};
			default: return {$urandom, $urandom} >> $urandom_range(8, 60);
		endcase
	endfunction

	// Leaves cfg_valid high; cfg_close lowers it
	task automatic cfg_write(pmes_pkg::cfg_idx_t idx, logic [pmes_pkg::CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send(logic [63:0] xc, logic [63:0] xe, logic [63:0] n, logic [63:0] w);
		in_valid <= 1'b1;
		commoners_in <= xc;
		elites_in <= xe;
		nature_in <= n;
		wealth_in <= w;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Drain the pipeline before touching registers
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_items(int count);
		repeat (count) begin
			send(pick_field(), pick_field(), pick_field(), pick_field());
			maybe_gap();
		end
	endtask

	task automatic load_regs(logic [31:0] am, logic [31:0] amax, logic [31:0] bc,
			logic [31:0] be, logic [31:0] g, logic [39:0] cap, logic [47:0] dep, logic [31:0] k);
		// upper data bits are junk on narrow registers; the block must drop them
		cfg_write(pmes_pkg::REG_HEALTHY_DEATH, {16'($urandom_range(0, 65535)), am});
		cfg_write(pmes_pkg::REG_FAMINE_DEATH, {16'($urandom_range(0, 65535)), amax});
		cfg_write(pmes_pkg::REG_COMMONER_BIRTH, {16'($urandom_range(0, 65535)), bc});
		cfg_write(pmes_pkg::REG_ELITE_BIRTH, {16'($urandom_range(0, 65535)), be});
		cfg_write(pmes_pkg::REG_REGEN, {16'($urandom_range(0, 65535)), g});
		cfg_write(pmes_pkg::REG_CAPACITY, {8'($urandom_range(0, 255)), cap});
		cfg_write(pmes_pkg::REG_DEPLETION, dep);
		cfg_write(pmes_pkg::REG_INEQUALITY, {16'($urandom_range(0, 65535)), k});
		cfg_write(pmes_pkg::cfg_idx_t'($urandom_range(8, 15)), 48'({$urandom, $urandom}));
		cfg_close();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: three directed items, then random ones, depletion and inequality off
		send(64'd0, 64'd0, 64'd0, 64'd0);
		send(64'd100 << 24, 64'd5 << 24, 64'd100 << 24, 64'd0);
		send('1, '1, '1, '1);
		random_items(40);
		settle_idle();

		// Plausible parameters, then the directed corners
		load_regs(32'd42949673, 32'd300647710, 32'd128849019, 32'd128849019,
			32'd42949673, 40'd100 << 24, 48'd1877, 32'd10 << 24);
		send(64'd0, 64'd0, 64'd50 << 24, 64'd10 << 24);          // zero threshold
		send(64'd100 << 24, 64'd1 << 24, 64'd100 << 24, 64'd0);   // no wealth, famine
		send(64'd100 << 24, 64'd1 << 24, 64'd100 << 24, '1);      // wealth above threshold
		send(64'd100 << 24, 64'd1 << 24, 64'd100 << 24, 64'd2 << 24); // ratio saturates at one
		send(64'd100 << 24, 64'd20 << 24, 64'd100 << 24, 64'd8 << 24); // elite quotient >= 1
		send(64'd0, 64'd7 << 24, 64'd0, 64'd3 << 24);
		send('1, 64'd0, '1, 64'd0);                             // nature collapses, saturates
		send(64'd0, '1, 64'd0, '1);
		send(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		random_items(200);
		settle_idle();

		// All registers zero
		load_regs('0, '0, '0, '0, '0, '0, '0, '0);
		random_items(120);
		settle_idle();

		// All registers at their maximum
		load_regs('1, '1, '1, '1, '1, '1, '1, '1);
		random_items(120);
		settle_idle();

		// Famine rate below healthy rate, random magnitudes
		load_regs(32'hF000_0000 | $urandom, $urandom_range(0, 32'h0FFF_FFFF), $urandom,
			$urandom, $urandom, 40'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			$urandom_range(0, 32'h0FFF_FFFF));
		random_items(200);
		settle_idle();

		// Fully random registers, last stretch without idling
		load_regs($urandom, $urandom, $urandom, $urandom, $urandom,
			40'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom);
		random_items(120);
		quiet = 1'b1;
		random_items(140);
		settle_idle();

		$display("ran %0d steps over six register settings, %0d results compared",
			items_sent, compared);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && pending == 0)
			$display("PASS population_model_euler_step_top");
		else
			$display("FAIL population_model_euler_step_top");
		$finish;
	end
endmodule
`default_nettype wire
